>>> hw/rtl/b64d_pkg.sv
// ----------------------------------------------------------------------------
// b64d_pkg
// Types, codes and the character decode function of the base64 decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package b64d_pkg;

  localparam logic [7:0] PAD_CHAR = 8'h3D;
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_CHAR = 2'd1,
    ST_BAD_PAD  = 2'd2,
    ST_BAD_LEN  = 2'd3
  } b64d_status_e;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
  } b64d_in_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       end_of_message;
    logic [1:0] status;
  } b64d_out_t;

  // one front-end command: one to three bytes, or a lone end result
  typedef struct packed {
    logic [7:0]   byte0;
    logic [7:0]   byte1;
    logic [7:0]   byte2;
    logic [1:0]   count;
    logic         has_bytes;
    logic         eom;
    b64d_status_e status;
  } b64d_cmd_t;

  typedef struct packed {
    logic bad;
    logic [5:0] value;
  } b64d_sextet_t;

  function automatic b64d_sextet_t sextet_of(logic [7:0] c);
    b64d_sextet_t r;
    r = '{bad: 1'b0, value: 6'd0};
    if (c inside {[8'h41:8'h5A]}) begin
      r.value = 6'(c - 8'h41);
    end else if (c inside {[8'h61:8'h7A]}) begin
      r.value = 6'(c - 8'h61 + 8'd26);
    end else if (c inside {[8'h30:8'h39]}) begin
      r.value = 6'(c - 8'h30 + 8'd52);
    end else if (c inside {8'h2B, 8'h2D}) begin
      r.value = 6'd62;
    end else if (c inside {8'h2F, 8'h5F}) begin
      r.value = 6'd63;
    end else begin
      r.bad = 1'b1;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/base64_stream_decoder.sv
// ----------------------------------------------------------------------------
// base64_stream_decoder
// Streaming base64 decoder, standard and URL-safe alphabets.
// ----------------------------------------------------------------------------
// Input channel: one character per item with a last-character flag.
// Output channel: one decoded byte per item; the final item of a message
// has end_of_message set and carries the status (nonzero: drop message).
// The fourth character of a quad yields one to three items; a message that
// fails yields a single status-only end item.
// Throughput: one character per cycle while in_stall_o is low; the output side
// moves one item per cycle while the receiver does not stall.
// A result item passes a queue entry, then the output register, before it is valid.
// A four-entry command queue decouples the two sides: when the receiver
// stalls, in_stall_o rises only after the queue fills.
// Reset clears the quad state, empties the queue and clears the output valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module base64_stream_decoder import b64d_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  input  wire b64d_in_t  in_data_i,
  output logic           in_stall_o,
  output logic           out_valid_o,
  output b64d_out_t      out_data_o,
  input  wire logic      out_stall_i
);

  logic      full;
  logic      push;
  logic      pop;
  logic      head_valid;
  b64d_cmd_t push_cmd;
  b64d_cmd_t head;

  assign in_stall_o = full;

  b64d_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (in_valid_i && !full),
    .in_data_i(in_data_i),
    .push_o   (push),
    .cmd_o    (push_cmd)
  );

  b64d_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_cmd_i  (push_cmd),
    .pop_i       (pop),
    .full_o      (full),
    .head_valid_o(head_valid),
    .head_o      (head)
  );

  b64d_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_valid_i(head_valid),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .out_stall_i (out_stall_i)
  );

endmodule

`default_nettype wire

>>> hw/rtl/b64d_front.sv
// ----------------------------------------------------------------------------
// b64d_front
// Accepts characters, tracks the quad and error state, issues commands.
// ----------------------------------------------------------------------------
`default_nettype none

module b64d_front import b64d_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      accept_i,
  input  wire b64d_in_t  in_data_i,
  output logic           push_o,
  output b64d_cmd_t      cmd_o
);

  logic [1:0]   pos_q, pos_d;
  logic [5:0]   first_q, first_d;
  logic [5:0]   second_q, second_d;
  logic [5:0]   third_q, third_d;
  logic         third_pad_q, third_pad_d;
  logic         err_q, err_d;
  b64d_status_e code_q, code_d;

  always_comb begin
    logic [7:0]   c;
    logic         last;
    b64d_sextet_t sx;
    logic [1:0]   n;
    logic         flag;
    b64d_status_e code;
    b64d_status_e status;

    c    = in_data_i.char_code;
    last = in_data_i.last_char;
    sx   = sextet_of(c);
    n    = 2'd0;
    flag = 1'b0;
    code = ST_BAD_CHAR;

    pos_d       = pos_q;
    first_d     = first_q;
    second_d    = second_q;
    third_d     = third_q;
    third_pad_d = third_pad_q;
    err_d       = err_q;
    code_d      = code_q;

    cmd_o.byte0     = {first_q, second_q[5:4]};
    cmd_o.byte1     = {second_q[3:0], third_q[5:2]};
    cmd_o.byte2     = {third_q[1:0], sx.value};
    cmd_o.count     = 2'd1;
    cmd_o.has_bytes = 1'b1;
    cmd_o.eom       = 1'b0;
    cmd_o.status    = ST_OK;

    if (!err_q) begin
      if (pos_q != 2'd3) begin
        if (pos_q == 2'd2 && c == PAD_CHAR) begin
          third_pad_d = 1'b1;
          third_d     = 6'd0;
        end else if (sx.bad) begin
          flag = 1'b1;
          code = (c == PAD_CHAR && pos_q != 2'd2) ? ST_BAD_PAD : ST_BAD_CHAR;
        end else begin
          case (pos_q)
            2'd0: first_d = sx.value;
            2'd1: second_d = sx.value;
            default: begin
              third_d     = sx.value;
              third_pad_d = 1'b0;
            end
          endcase
        end
      end else if (third_pad_q) begin
        if (c != PAD_CHAR || !last) begin
          flag = 1'b1;
          code = ST_BAD_PAD;
        end else begin
          n = 2'd1;
        end
      end else if (c == PAD_CHAR) begin
        if (!last) begin
          flag = 1'b1;
          code = ST_BAD_PAD;
        end else begin
          n = 2'd2;
        end
      end else if (sx.bad) begin
        flag = 1'b1;
        code = ST_BAD_CHAR;
      end else begin
        n = 2'd3;
      end
    end

    if (flag) begin
      err_d  = 1'b1;
      code_d = code;
    end
    pos_d = pos_q + 2'd1;

    if (pos_q != 2'd3) begin
      status = ST_BAD_LEN;
    end else if (err_q) begin
      status = code_q;
    end else if (flag) begin
      status = code;
    end else begin
      status = ST_OK;
    end

    cmd_o.count = (n == 2'd0) ? 2'd1 : n;
    push_o      = accept_i && (n != 2'd0 || last);

    if (last) begin
      cmd_o.eom = 1'b1;
      if (n == 2'd0 || status != ST_OK) begin
        cmd_o.byte0     = 8'd0;
        cmd_o.count     = 2'd1;
        cmd_o.has_bytes = 1'b0;
        cmd_o.status    = status;
      end
      pos_d       = 2'd0;
      first_d     = 6'd0;
      second_d    = 6'd0;
      third_d     = 6'd0;
      third_pad_d = 1'b0;
      err_d       = 1'b0;
      code_d      = ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= 2'd0;
      first_q     <= 6'd0;
      second_q    <= 6'd0;
      third_q     <= 6'd0;
      third_pad_q <= 1'b0;
      err_q       <= 1'b0;
      code_q      <= ST_OK;
    end else if (accept_i) begin
      pos_q       <= pos_d;
      first_q     <= first_d;
      second_q    <= second_d;
      third_q     <= third_d;
      third_pad_q <= third_pad_d;
      err_q       <= err_d;
      code_q      <= code_d;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/b64d_queue.sv
// ----------------------------------------------------------------------------
// b64d_queue
// Short command FIFO between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

module b64d_queue import b64d_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      push_i,
  input  wire b64d_cmd_t push_cmd_i,
  input  wire logic      pop_i,
  output logic           full_o,
  output logic           head_valid_o,
  output b64d_cmd_t      head_o
);

  b64d_cmd_t         mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] cnt_q;

  assign full_o       = (cnt_q == QCNT_W'(QDEPTH));
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      end
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + QCNT_W'(1);
        2'b01:   cnt_q <= cnt_q - QCNT_W'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/b64d_back.sv
// ----------------------------------------------------------------------------
// b64d_back
// Expands commands into result items through the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module b64d_back import b64d_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      head_valid_i,
  input  wire b64d_cmd_t head_i,
  output logic           pop_o,
  output logic           out_valid_o,
  output b64d_out_t      out_data_o,
  input  wire logic      out_stall_i
);

  logic [1:0] idx_q, idx_d;
  logic       out_valid_q, out_valid_d;
  b64d_out_t  out_q, out_d;
  logic       load;
  logic       last_idx;

  always_comb begin
    load     = head_valid_i && (!out_valid_q || !out_stall_i);
    last_idx = (idx_q == head_i.count - 2'd1);
    pop_o    = load && last_idx;
    idx_d    = idx_q;
    out_d    = out_q;
    if (load) begin
      idx_d = last_idx ? 2'd0 : idx_q + 2'd1;
      case (idx_q)
        2'd0:    out_d.data_byte = head_i.byte0;
        2'd1:    out_d.data_byte = head_i.byte1;
        default: out_d.data_byte = head_i.byte2;
      endcase
      out_d.byte_valid     = head_i.has_bytes;
      out_d.end_of_message = head_i.eom && last_idx;
      out_d.status         = head_i.status;
    end
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_stall_i) begin
      out_valid_d = out_valid_q;
    end else begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

>>> hw/rtl/b64d_checker.sv
// ----------------------------------------------------------------------------
// b64d_checker
// Port-level checks on the base64 decoder output channel.
// ----------------------------------------------------------------------------
`default_nettype none

module b64d_checker import b64d_pkg::*; (
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      out_valid_o,
  input wire b64d_out_t out_data_o,
  input wire logic      out_stall_i
);

  a_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output item dropped while stalled");

  a_empty_byte_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.byte_valid |-> out_data_o.data_byte == 8'd0)
    else $error("status-only item carries data");

  a_status_on_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.end_of_message |-> out_data_o.status == ST_OK)
    else $error("status set on a non-final item");

  a_error_no_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status != ST_OK |-> !out_data_o.byte_valid)
    else $error("byte delivered with an error status");

endmodule

bind base64_stream_decoder b64d_checker u_b64d_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid_o(out_valid_o),
  .out_data_o (out_data_o),
  .out_stall_i(out_stall_i)
);

`default_nettype wire

>>> test/base64_stream_decoder_test.sv
// ----------------------------------------------------------------------------
// base64_stream_decoder_test
// Self-checking testbench for the streaming base64 decoder.
// ----------------------------------------------------------------------------
// A driver feeds characters from a queue of messages: a short directed set
// (padding forms, misplaced pads, bad characters, odd lengths), then random
// messages, mostly valid encodings with some corrupted, noisy or of the wrong length.
// A decode model tracks the quad state and queues the items it expects.
// The monitor checks every output item, field by field, against that queue.
// Both sides idle at random in the first two of three phases; the sender
// sometimes holds off until every expected item has come out.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module base64_stream_decoder_test;
  import b64d_pkg::*;

  localparam int RANDOM_CHARS = 294;
  localparam int QUIET_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 8;

  typedef struct {
    b64d_in_t   item;
    bit         drain;
    logic [1:0] phase;
  } char_slot_t;

  typedef enum {
    MSG_CLEAN,
    MSG_CORRUPT,
    MSG_NOISE,
    MSG_BAD_LEN
  } msg_kind_e;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  b64d_in_t  in_data_i = '0;
  logic      in_stall_o;
  logic      out_valid_o;
  b64d_out_t out_data_o;
  logic      out_stall_i = 1'b0;

  base64_stream_decoder u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_data_i  (in_data_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_data_o (out_data_o),
    .out_stall_i(out_stall_i)
  );

  char_slot_t   char_queue[$];
  logic [7:0]   msg_buf[$];
  b64d_out_t    expected_items[$];
  bit           in_busy = 1'b0;
  logic [1:0]   cur_phase = 2'd0;
  int           n_queued = 0;
  int           quiet_cycles = 0;
  int           fail_count = 0;
  int           n_chars = 0;
  int           n_items = 0;
  int           n_bytes = 0;
  int           status_seen[4] = '{0, 0, 0, 0};

  // decode state
  logic [1:0]   quad_slot = 2'd0;
  logic [5:0]   sx0 = '0, sx1 = '0, sx2 = '0;
  logic         third_pad = 1'b0;
  logic         err_seen = 1'b0;
  b64d_status_e err_code = ST_OK;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
  end

  // ---------------------------------------------------------------- decode
  function automatic logic [6:0] char_sextet(logic [7:0] c);
    if (c >= "A" && c <= "Z") return {1'b0, 6'(c - "A")};
    if (c >= "a" && c <= "z") return {1'b0, 6'(c - "a" + 8'd26)};
    if (c >= "0" && c <= "9") return {1'b0, 6'(c - "0" + 8'd52)};
    if (c == "+" || c == "-") return 7'd62;
    if (c == "/" || c == "_") return 7'd63;
    return 7'h40;
  endfunction

  function automatic b64d_out_t mk_item(logic [7:0] d, logic v, logic e, logic [1:0] s);
    b64d_out_t r;
    r.data_byte      = d;
    r.byte_valid     = v;
    r.end_of_message = e;
    r.status         = s;
    return r;
  endfunction

  function automatic void note_error(b64d_status_e code);
    if (!err_seen) begin
      err_seen = 1'b1;
      err_code = code;
    end
  endfunction

  function automatic void decode_char(b64d_in_t it);
    b64d_out_t    res[$];
    logic [7:0]   b0, b1, b2;
    logic [6:0]   v;
    logic [1:0]   pos;
    b64d_status_e st;
    pos = quad_slot;
    if (!err_seen) begin
      if (pos != 2'd3) begin
        if (pos == 2'd2 && it.char_code == PAD_CHAR) begin
          third_pad = 1'b1;
          sx2 = '0;
        end else begin
          v = char_sextet(it.char_code);
          if (v[6]) begin
            note_error((it.char_code == PAD_CHAR && pos < 2'd2) ? ST_BAD_PAD : ST_BAD_CHAR);
          end else begin
            case (pos)
              2'd0: sx0 = v[5:0];
              2'd1: sx1 = v[5:0];
              default: begin
                sx2 = v[5:0];
                third_pad = 1'b0;
              end
            endcase
          end
        end
      end else begin
        b0 = {sx0, sx1[5:4]};
        b1 = {sx1[3:0], sx2[5:2]};
        if (third_pad) begin
          if (it.char_code != PAD_CHAR || !it.last_char) begin
            note_error(ST_BAD_PAD);
          end else begin
            res.insert(res.size(), mk_item(b0, 1'b1, 1'b0, ST_OK));
          end
        end else if (it.char_code == PAD_CHAR) begin
          if (!it.last_char) begin
            note_error(ST_BAD_PAD);
          end else begin
            res.insert(res.size(), mk_item(b0, 1'b1, 1'b0, ST_OK));
            res.insert(res.size(), mk_item(b1, 1'b1, 1'b0, ST_OK));
          end
        end else begin
          v = char_sextet(it.char_code);
          if (v[6]) begin
            note_error(ST_BAD_CHAR);
          end else begin
            b2 = {sx2[1:0], v[5:0]};
            res.insert(res.size(), mk_item(b0, 1'b1, 1'b0, ST_OK));
            res.insert(res.size(), mk_item(b1, 1'b1, 1'b0, ST_OK));
            res.insert(res.size(), mk_item(b2, 1'b1, 1'b0, ST_OK));
          end
        end
      end
    end
    quad_slot = pos + 2'd1;
    if (it.last_char) begin
      if (pos != 2'd3) st = ST_BAD_LEN;
      else if (err_seen) st = err_code;
      else st = ST_OK;
      if (res.size() > 0 && st == ST_OK) begin
        res[res.size() - 1].end_of_message = 1'b1;
      end else begin
        res.delete();
        res.insert(res.size(), mk_item(8'd0, 1'b0, 1'b1, st));
      end
      quad_slot = 2'd0;
      sx0 = '0;
      sx1 = '0;
      sx2 = '0;
      third_pad = 1'b0;
      err_seen = 1'b0;
      err_code = ST_OK;
    end
    foreach (res[i]) expected_items.insert(expected_items.size(), res[i]);
  endfunction

  // -------------------------------------------------------------- stimulus
  function automatic void put_char(logic [7:0] c);
    msg_buf.insert(msg_buf.size(), c);
  endfunction

  function automatic logic [7:0] alphabet_char(logic [5:0] s);
    if (s < 6'd26) return 8'("A" + s);
    if (s < 6'd52) return 8'("a" + s - 6'd26);
    if (s < 6'd62) return 8'("0" + s - 6'd52);
    if (s == 6'd62) return $urandom_range(0, 1) ? "+" : "-";
    return $urandom_range(0, 1) ? "/" : "_";
  endfunction

  function automatic logic [7:0] noise_char();
    case ($urandom_range(0, 2))
      0: return 8'($urandom);
      1: return alphabet_char(6'($urandom));
      default: return PAD_CHAR;
    endcase
  endfunction

  function automatic logic [7:0] data_value();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic encode_bytes(input int count);
    logic [7:0] b[3];
    logic [5:0] s[4];
    int k;
    for (int i = 0; i < count; i += 3) begin
      k = (count - i >= 3) ? 3 : count - i;
      b[0] = data_value();
      b[1] = (k > 1) ? data_value() : 8'd0;
      b[2] = (k > 2) ? data_value() : 8'd0;
      s[0] = b[0][7:2];
      s[1] = {b[0][1:0], b[1][7:4]};
      s[2] = {b[1][3:0], b[2][7:6]};
      s[3] = b[2][5:0];
      // stray bits below the padding
      if (k == 1 && $urandom_range(0, 3) == 0) s[1][3:0] = 4'($urandom);
      if (k == 2 && $urandom_range(0, 3) == 0) s[2][1:0] = 2'($urandom);
      put_char(alphabet_char(s[0]));
      put_char(alphabet_char(s[1]));
      put_char((k > 1) ? alphabet_char(s[2]) : PAD_CHAR);
      put_char((k > 2) ? alphabet_char(s[3]) : PAD_CHAR);
    end
  endtask

  task automatic queue_message(input logic [1:0] phase, input bit drain_first);
    char_slot_t slot;
    foreach (msg_buf[i]) begin
      slot.item.char_code = msg_buf[i];
      slot.item.last_char = (i == msg_buf.size() - 1);
      slot.drain = drain_first && (i == 0);
      slot.phase = phase;
      char_queue.insert(char_queue.size(), slot);
      n_queued++;
    end
    msg_buf.delete();
  endtask

  task automatic queue_text(input string s);
    for (int i = 0; i < s.len(); i++) put_char(s[i]);
    queue_message(2'd0, 1'b0);
  endtask

  initial begin : stimulus
    logic [1:0] phase;
    logic [1:0] prev_phase;
    msg_kind_e  kind;
    int         idx;
    int         pick;

    queue_text("9-==");        // one byte, nonzero unused bits
    queue_text("Az_=");        // two bytes
    queue_text("=Z-a");        // pad in slot one
    queue_text("AB=x");        // data after a slot-three pad
    msg_buf = '{"A", 8'hFF, "A", "A"};
    queue_message(2'd0, 1'b0);
    queue_text("AB==A");       // pad in an inner quad, then bad length wins
    msg_buf = '{8'h00};
    queue_message(2'd0, 1'b0);

    prev_phase = 2'd0;
    while (n_queued < 26 + RANDOM_CHARS) begin
      phase = (n_queued < 26 + RANDOM_CHARS / 3) ? 2'd0 :
              (n_queued < 26 + 2 * RANDOM_CHARS / 3) ? 2'd1 : 2'd2;
      pick = $urandom_range(0, 9);
      kind = (pick < 7) ? MSG_CLEAN : (pick == 7) ? MSG_CORRUPT :
             (pick == 8) ? MSG_NOISE : MSG_BAD_LEN;
      case (kind)
        MSG_CLEAN: encode_bytes($urandom_range(1, 9));
        MSG_CORRUPT: begin
          encode_bytes($urandom_range(1, 9));
          idx = $urandom_range(0, msg_buf.size() - 1);
          msg_buf[idx] = ($urandom_range(0, 2) == 0) ? PAD_CHAR : 8'($urandom);
        end
        MSG_NOISE: repeat ($urandom_range(1, 9)) put_char(noise_char());
        default: begin
          encode_bytes($urandom_range(1, 9));
          if ($urandom_range(0, 1)) void'(msg_buf.pop_back());
          else put_char(noise_char());
        end
      endcase
      queue_message(phase, phase != prev_phase || $urandom_range(0, 7) == 0);
      prev_phase = phase;
    end

    while (char_queue.size() != 0 || in_busy || expected_items.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Decoded %0d characters into %0d output items (%0d data bytes).",
             n_chars, n_items, n_bytes);
    $display("Message status counts: ok %0d, bad char %0d, bad pad %0d, bad length %0d.",
             status_seen[ST_OK], status_seen[ST_BAD_CHAR], status_seen[ST_BAD_PAD],
             status_seen[ST_BAD_LEN]);
    if (fail_count == 0) begin
      $display("** base64_stream_decoder: PASSED **");
    end else begin
      $display("** base64_stream_decoder: FAILED **");
    end
    $finish;
  end

  // ---------------------------------------------------------------- driver
  function automatic int tx_idle_pct(logic [1:0] phase);
    case (phase)
      2'd0: return 37;
      2'd1: return 69;
      default: return 0;
    endcase
  endfunction

  function automatic int rx_stall_pct(logic [1:0] phase);
    case (phase)
      2'd0: return 69;
      2'd1: return 37;
      default: return 0;
    endcase
  endfunction

  always @(negedge clk_i) begin
    if (rst_ni) begin
      out_stall_i <= ($urandom_range(0, 99) < rx_stall_pct(cur_phase));
      if (!in_busy) begin
        if (char_queue.size() == 0) begin
          in_valid_i <= 1'b0;
        end else if (char_queue[0].drain && expected_items.size() != 0) begin
          in_valid_i <= 1'b0;
        end else begin
          cur_phase = char_queue[0].phase;
          if ($urandom_range(0, 99) < tx_idle_pct(cur_phase)) begin
            in_valid_i <= 1'b0;
          end else begin
            in_data_i <= char_queue.pop_front().item;
            in_valid_i <= 1'b1;
            in_busy = 1'b1;
          end
        end
      end
    end
  end

  // --------------------------------------------------------------- monitor
  task automatic check_field(input string name, input logic [7:0] exp_v,
                             input logic [7:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, got_v);
      fail_count++;
    end
  endtask

  always @(posedge clk_i) begin
    b64d_out_t exp_item;
    bit        moved;
    if (rst_ni) begin
      moved = 1'b0;
      if (out_valid_o && !out_stall_i) begin
        moved = 1'b1;
        n_items++;
        if (out_data_o.byte_valid) n_bytes++;
        if (out_data_o.end_of_message) status_seen[out_data_o.status]++;
        if (expected_items.size() == 0) begin
          $error("unexpected output item %0h", out_data_o);
          fail_count++;
        end else begin
          exp_item = expected_items.pop_front();
          check_field("data_byte", exp_item.data_byte, out_data_o.data_byte);
          check_field("byte_valid", 8'(exp_item.byte_valid), 8'(out_data_o.byte_valid));
          check_field("end_of_message", 8'(exp_item.end_of_message),
                      8'(out_data_o.end_of_message));
          check_field("status", 8'(exp_item.status), 8'(out_data_o.status));
        end
      end
      if (in_valid_i && !in_stall_o) begin
        moved = 1'b1;
        n_chars++;
        decode_char(in_data_i);
        in_busy = 1'b0;
      end
      quiet_cycles <= moved ? 0 : quiet_cycles + 1;
    end
  end

  initial begin : watchdog
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk_i);
    $display("No handshake for %0d cycles, %0d items still expected.",
             QUIET_LIMIT, expected_items.size());
    $display("** base64_stream_decoder: FAILED **");
    $finish;
  end

endmodule
